/* rtl/md5_pkg.sv */
// Shared types, constants and round functions for the MD5 hash engine.
// Used by md5_ctrl, md5_datapath and md5_hash_engine; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package md5_pkg;

  localparam int unsigned PadLimit = 55;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;

  localparam logic [7:0] PAD_MARK = 8'h80;

  localparam logic [1:0] WORD_A = 2'd0;
  localparam logic [1:0] WORD_D = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       is_last;
  } md5_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
  } md5_out_t;

  typedef struct packed {
    logic       take_byte;
    logic       prep;
    logic       round;
    logic [5:0] idx;
    logic       fold;
    logic       finish;
    logic       mark_en;
    logic       len_en;
  } md5_cmd_t;

  typedef struct packed {
    logic [5:0] pos;
  } md5_stat_t;

  function automatic logic [31:0] md5_rotl(input logic [31:0] x, input logic [4:0] s);
    logic [63:0] dbl;
    dbl = {x, x} << s;
    return dbl[63:32];
  endfunction

  function automatic logic [4:0] md5_s(input logic [5:0] i);
    logic [4:0] s;
    case ({i[5:4], i[1:0]})
      4'd0:    s = 5'd7;
      4'd1:    s = 5'd12;
      4'd2:    s = 5'd17;
      4'd3:    s = 5'd22;
      4'd4:    s = 5'd5;
      4'd5:    s = 5'd9;
      4'd6:    s = 5'd14;
      4'd7:    s = 5'd20;
      4'd8:    s = 5'd4;
      4'd9:    s = 5'd11;
      4'd10:   s = 5'd16;
      4'd11:   s = 5'd23;
      4'd12:   s = 5'd6;
      4'd13:   s = 5'd10;
      4'd14:   s = 5'd15;
      4'd15:   s = 5'd21;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

  function automatic logic [3:0] md5_g(input logic [5:0] i);
    logic [3:0] lo;
    logic [3:0] g;
    lo = i[3:0];
    case (i[5:4])
      2'd0:    g = lo;
      2'd1:    g = lo + (lo << 2) + 4'd1;
      2'd2:    g = lo + (lo << 1) + 4'd5;
      2'd3:    g = (lo << 3) - lo;
      default: g = lo;
    endcase
    return g;
  endfunction

  function automatic logic [31:0] md5_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0:    k = 32'hd76aa478;
      6'd1:    k = 32'he8c7b756;
      6'd2:    k = 32'h242070db;
      6'd3:    k = 32'hc1bdceee;
      6'd4:    k = 32'hf57c0faf;
      6'd5:    k = 32'h4787c62a;
      6'd6:    k = 32'ha8304613;
      6'd7:    k = 32'hfd469501;
      6'd8:    k = 32'h698098d8;
      6'd9:    k = 32'h8b44f7af;
      6'd10:   k = 32'hffff5bb1;
      6'd11:   k = 32'h895cd7be;
      6'd12:   k = 32'h6b901122;
      6'd13:   k = 32'hfd987193;
      6'd14:   k = 32'ha679438e;
      6'd15:   k = 32'h49b40821;
      6'd16:   k = 32'hf61e2562;
      6'd17:   k = 32'hc040b340;
      6'd18:   k = 32'h265e5a51;
      6'd19:   k = 32'he9b6c7aa;
      6'd20:   k = 32'hd62f105d;
      6'd21:   k = 32'h02441453;
      6'd22:   k = 32'hd8a1e681;
      6'd23:   k = 32'he7d3fbc8;
      6'd24:   k = 32'h21e1cde6;
      6'd25:   k = 32'hc33707d6;
      6'd26:   k = 32'hf4d50d87;
      6'd27:   k = 32'h455a14ed;
      6'd28:   k = 32'ha9e3e905;
      6'd29:   k = 32'hfcefa3f8;
      6'd30:   k = 32'h676f02d9;
      6'd31:   k = 32'h8d2a4c8a;
      6'd32:   k = 32'hfffa3942;
      6'd33:   k = 32'h8771f681;
      6'd34:   k = 32'h6d9d6122;
      6'd35:   k = 32'hfde5380c;
      6'd36:   k = 32'ha4beea44;
      6'd37:   k = 32'h4bdecfa9;
      6'd38:   k = 32'hf6bb4b60;
      6'd39:   k = 32'hbebfbc70;
      6'd40:   k = 32'h289b7ec6;
      6'd41:   k = 32'heaa127fa;
      6'd42:   k = 32'hd4ef3085;
      6'd43:   k = 32'h04881d05;
      6'd44:   k = 32'hd9d4d039;
      6'd45:   k = 32'he6db99e5;
      6'd46:   k = 32'h1fa27cf8;
      6'd47:   k = 32'hc4ac5665;
      6'd48:   k = 32'hf4292244;
      6'd49:   k = 32'h432aff97;
      6'd50:   k = 32'hab9423a7;
      6'd51:   k = 32'hfc93a039;
      6'd52:   k = 32'h655b59c3;
      6'd53:   k = 32'h8f0ccc92;
      6'd54:   k = 32'hffeff47d;
      6'd55:   k = 32'h85845dd1;
      6'd56:   k = 32'h6fa87e4f;
      6'd57:   k = 32'hfe2ce6e0;
      6'd58:   k = 32'ha3014314;
      6'd59:   k = 32'h4e0811a1;
      6'd60:   k = 32'hf7537e82;
      6'd61:   k = 32'hbd3af235;
      6'd62:   k = 32'h2ad7d2bb;
      6'd63:   k = 32'heb86d391;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

/* rtl/md5_datapath.sv */
// Datapath of the MD5 hash engine: block buffer, padding view, round logic,
// chaining value, length counter and digest buffer. Depends on md5_pkg.
`timescale 1ns / 1ps
`default_nettype none

module md5_datapath (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire md5_pkg::md5_cmd_t cmd,
  input  wire md5_pkg::md5_in_t  req,
  input  wire logic [1:0]        out_idx,
  output md5_pkg::md5_stat_t     stat,
  output logic [31:0]            digest_word
);
  import md5_pkg::*;

  logic [31:0] words [16];
  logic [31:0] chain [4];
  logic [31:0] digest [4];
  logic [31:0] ra, rb, rc, rd;
  logic [31:0] pre;
  logic [60:0] msg_bytes;
  logic [5:0]  pos;

  logic [5:0]  nidx;
  logic [3:0]  g;
  logic [31:0] w_raw, w_eff;
  logic [63:0] bit_len;
  logic [31:0] a_src, pre_next;
  logic [31:0] fv, rot, b_next;

  assign nidx    = cmd.prep ? 6'd0 : cmd.idx + 6'd1;
  assign g       = md5_g(nidx);
  assign w_raw   = words[g];
  assign bit_len = {msg_bytes, 3'b000};

  always_comb begin
    logic [5:0] bidx;
    bidx  = '0;
    w_eff = w_raw;
    if (cmd.mark_en) begin
      for (int j = 0; j < 4; j++) begin
        bidx = {g, 2'(j)};
        if (bidx == pos) begin
          w_eff[8*j +: 8] = PAD_MARK;
        end else if (bidx > pos) begin
          w_eff[8*j +: 8] = 8'h00;
        end
      end
    end else if (cmd.len_en) begin
      w_eff = 32'h0;
    end
    if (cmd.len_en && g == 4'd14) begin
      w_eff = bit_len[31:0];
    end else if (cmd.len_en && g == 4'd15) begin
      w_eff = bit_len[63:32];
    end
  end

  assign a_src    = cmd.prep ? chain[0] : rd;
  assign pre_next = a_src + md5_k(nidx) + w_eff;

  always_comb begin
    case (cmd.idx[5:4])
      2'd0:    fv = (rb & rc) | (~rb & rd);
      2'd1:    fv = (rd & rb) | (~rd & rc);
      2'd2:    fv = rb ^ rc ^ rd;
      2'd3:    fv = rc ^ (rb | ~rd);
      default: fv = 32'h0;
    endcase
  end

  assign rot    = md5_rotl(pre + fv, md5_s(cmd.idx));
  assign b_next = rb + rot;

  always_ff @(posedge clk) begin
    if (cmd.take_byte) begin
      words[pos[5:2]][{pos[1:0], 3'b000} +: 8] <= req.data_byte;
    end
    if (cmd.prep) begin
      ra  <= chain[0];
      rb  <= chain[1];
      rc  <= chain[2];
      rd  <= chain[3];
      pre <= pre_next;
    end else if (cmd.round) begin
      ra  <= rd;
      rb  <= b_next;
      rc  <= rb;
      rd  <= rc;
      pre <= pre_next;
    end
    if (cmd.finish) begin
      for (int k = 0; k < 4; k++) begin
        digest[k] <= chain[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      chain[0]  <= IV_A;
      chain[1]  <= IV_B;
      chain[2]  <= IV_C;
      chain[3]  <= IV_D;
      msg_bytes <= '0;
      pos       <= '0;
    end else begin
      if (cmd.fold) begin
        chain[0] <= chain[0] + ra;
        chain[1] <= chain[1] + rb;
        chain[2] <= chain[2] + rc;
        chain[3] <= chain[3] + rd;
      end
      if (cmd.take_byte) begin
        msg_bytes <= msg_bytes + 61'd1;
        pos       <= pos + 6'd1;
      end
    end
  end

  assign stat.pos    = pos;
  assign digest_word = digest[out_idx];

`ifndef SYNTHESIS
  a_finish_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> pos == 6'd0 && msg_bytes == 61'd0 && chain[0] == IV_A)
    else $error("finish did not return the engine to the initial vector");
  a_digest_captured: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> digest[3] == $past(chain[3]))
    else $error("digest buffer did not capture the chaining value");
  a_pos_tracks_count: assert property (@(posedge clk) disable iff (rst)
    pos == msg_bytes[5:0])
    else $error("block position lost track of the byte count");
`endif

endmodule

`default_nettype wire

/* rtl/md5_ctrl.sv */
// Controller of the MD5 hash engine: request intake, block and padding
// sequencing, round counter and digest output handshake. Depends on md5_pkg.
`timescale 1ns / 1ps
`default_nettype none

module md5_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               msg_valid,
  output logic                    msg_stall,
  input  wire md5_pkg::md5_in_t   req,
  output logic                    dig_valid,
  input  wire logic               dig_stall,
  output logic [1:0]              out_idx,
  input  wire md5_pkg::md5_stat_t stat,
  output md5_pkg::md5_cmd_t       cmd
);
  import md5_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_PREP  = 5'b00010,
    S_ROUND = 5'b00100,
    S_FOLD  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t     state, state_next;
  logic [5:0] cnt, cnt_next;
  logic       mark_en, mark_en_next;
  logic       len_en, len_en_next;
  logic       fin, fin_next;
  logic       out_busy, out_busy_next;
  logic [1:0] out_idx_next;
  logic [5:0] pos_eff;
  logic       take;

  assign msg_stall = (state != S_IDLE);
  assign take      = msg_valid && !msg_stall;
  assign pos_eff   = stat.pos + {5'd0, req.has_byte};

  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    mark_en_next  = mark_en;
    len_en_next   = len_en;
    fin_next      = fin;
    out_busy_next = out_busy;
    out_idx_next  = out_idx;

    cmd           = '0;
    cmd.idx       = cnt;
    cmd.mark_en   = mark_en;
    cmd.len_en    = len_en;
    cmd.take_byte = take && req.has_byte;

    if (dig_valid && !dig_stall) begin
      if (out_idx == WORD_D) begin
        out_busy_next = 1'b0;
        out_idx_next  = WORD_A;
      end else begin
        out_idx_next = out_idx + 2'd1;
      end
    end

    case (state)
      S_IDLE: begin
        if (take) begin
          if (req.has_byte && stat.pos == 6'd63) begin
            mark_en_next = 1'b0;
            len_en_next  = 1'b0;
            fin_next     = req.is_last;
            state_next   = S_PREP;
          end else if (req.is_last) begin
            mark_en_next = 1'b1;
            len_en_next  = (32'(pos_eff) <= PadLimit);
            fin_next     = 1'b1;
            state_next   = S_PREP;
          end
        end
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        cnt_next   = 6'd0;
        state_next = S_ROUND;
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        cnt_next  = cnt + 6'd1;
        if (cnt == 6'd63) begin
          state_next = S_FOLD;
        end
      end
      S_FOLD: begin
        cmd.fold = 1'b1;
        if (len_en) begin
          state_next = S_DONE;
        end else if (fin) begin
          if (mark_en) begin
            mark_en_next = 1'b0;
            len_en_next  = 1'b1;
          end else begin
            mark_en_next = 1'b1;
            len_en_next  = (32'(stat.pos) <= PadLimit);
          end
          state_next = S_PREP;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_DONE: begin
        if (!out_busy) begin
          cmd.finish    = 1'b1;
          out_busy_next = 1'b1;
          out_idx_next  = WORD_A;
          fin_next      = 1'b0;
          mark_en_next  = 1'b0;
          len_en_next   = 1'b0;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      mark_en  <= 1'b0;
      len_en   <= 1'b0;
      fin      <= 1'b0;
      out_busy <= 1'b0;
      out_idx  <= WORD_A;
    end else begin
      state    <= state_next;
      cnt      <= cnt_next;
      mark_en  <= mark_en_next;
      len_en   <= len_en_next;
      fin      <= fin_next;
      out_busy <= out_busy_next;
      out_idx  <= out_idx_next;
    end
  end

  assign dig_valid = out_busy;

`ifndef SYNTHESIS
  a_round_count: assert property (@(posedge clk) disable iff (rst)
    state == S_ROUND && cnt == 6'd63 |=> state == S_FOLD)
    else $error("round sequence did not end after the last round");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !out_busy)
    else $error("digest loaded while the previous digest was still pending");
  a_output_start: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_busy && out_idx == WORD_A)
    else $error("digest output did not start at word A");
  a_done_needs_length: assert property (@(posedge clk) disable iff (rst)
    state == S_FOLD && !len_en |=> state != S_DONE)
    else $error("digest finished without the length block");
`endif

endmodule

`default_nettype wire

/* rtl/md5_hash_engine.sv */
// A request is taken while the engine is idle; the request that fills a block starts a load,
// 64 rounds of the single round unit and a chaining add, with requests stalled meanwhile.
// A last request adds one or two padding blocks, then the digest is loaded once the previous
// digest has left; the four digest words then leave one per cycle while the receiver does not stall.
// Reset (rst, synchronous) loads the initial vector, clears the length and block position,
// and empties the output; block buffer and round registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module md5_hash_engine (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              msg_valid,
  output logic                   msg_stall,
  input  wire md5_pkg::md5_in_t  msg,
  output logic                   dig_valid,
  input  wire logic              dig_stall,
  output md5_pkg::md5_out_t      dig
);
  import md5_pkg::*;

  md5_cmd_t    cmd;
  md5_stat_t   stat;
  logic [1:0]  out_idx;
  logic [31:0] digest_word;

  md5_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .msg_valid (msg_valid),
    .msg_stall (msg_stall),
    .req       (msg),
    .dig_valid (dig_valid),
    .dig_stall (dig_stall),
    .out_idx   (out_idx),
    .stat      (stat),
    .cmd       (cmd)
  );

  md5_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .req         (msg),
    .out_idx     (out_idx),
    .stat        (stat),
    .digest_word (digest_word)
  );

  assign dig.digest_word = digest_word;
  assign dig.word_index  = out_idx;
  assign dig.last_word   = (out_idx == WORD_D);

endmodule

`default_nettype wire

/* verif/md5_digest_checker.sv */
// md5_digest_checker: watches the request and digest channels of md5_hash_engine, runs its
// own MD5 model on every accepted request and compares each digest word in order.
// Depends on md5_pkg for the channel types, the initial vector and the padding constants.
`timescale 1ns / 1ps

module md5_digest_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              msg_valid,
  input  logic              msg_stall,
  input  md5_pkg::md5_in_t  msg,
  input  logic              dig_valid,
  input  logic              dig_stall,
  input  md5_pkg::md5_out_t dig,
  output int                mismatches,
  output int                pending
);
  import md5_pkg::*;

  localparam logic [2047:0] SINE_TABLE = {
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [79:0] SHIFT_TABLE = {
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  logic [31:0] chain [4];
  logic [31:0] words [16];
  logic [60:0] byte_count;
  logic [5:0]  slot;
  md5_out_t    digest_due [$];

  function automatic logic [31:0] rotate_left(input logic [31:0] x, input int s);
    return (x << s) | (x >> (32 - s));
  endfunction

  task automatic restart_message();
    chain[0] = IV_A;
    chain[1] = IV_B;
    chain[2] = IV_C;
    chain[3] = IV_D;
    byte_count = '0;
    slot = '0;
  endtask

  task automatic put_byte(input int pos, input logic [7:0] v);
    logic [31:0] w;
    if (pos % 4 == 0) begin
      words[pos / 4] = {24'h0, v};
    end else begin
      w = words[pos / 4];
      w[(pos % 4) * 8 +: 8] = v;
      words[pos / 4] = w;
    end
  endtask

  task automatic md5_compress();
    logic [31:0] a, b, c, d, f, t;
    int i, g, sh;
    a = chain[0];
    b = chain[1];
    c = chain[2];
    d = chain[3];
    for (i = 0; i < 64; i++) begin
      case (i / 16)
        0: begin
          f = (b & c) | (~b & d);
          g = i;
        end
        1: begin
          f = (d & b) | (~d & c);
          g = (5 * i + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * i + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * i) % 16;
        end
      endcase
      sh = int'(SHIFT_TABLE[(15 - ((i / 16) * 4 + i % 4)) * 5 +: 5]);
      t = rotate_left(a + f + SINE_TABLE[(63 - i) * 32 +: 32] + words[g], sh) + b;
      a = d;
      d = c;
      c = b;
      b = t;
    end
    chain[0] = chain[0] + a;
    chain[1] = chain[1] + b;
    chain[2] = chain[2] + c;
    chain[3] = chain[3] + d;
  endtask

  task automatic md5_absorb(input md5_in_t item);
    logic [63:0] bit_len;
    md5_out_t    due;
    int          p;
    if (item.has_byte) begin
      put_byte(int'(slot), item.data_byte);
      byte_count = byte_count + 1'b1;
      slot = slot + 1'b1;
      if (slot == 0) md5_compress();
    end
    if (item.is_last) begin
      put_byte(int'(slot), PAD_MARK);
      for (p = slot + 1; p < 64; p++) put_byte(p, 8'h00);
      // Too little room left for the length: it goes into a block of its own.
      if (slot > PadLimit) begin
        md5_compress();
        for (p = 0; p < 16; p++) words[p] = '0;
      end
      bit_len = {byte_count, 3'b000};
      words[14] = bit_len[31:0];
      words[15] = bit_len[63:32];
      md5_compress();
      for (p = 0; p < 4; p++) begin
        due.digest_word = chain[p];
        due.word_index = p[1:0];
        due.last_word = (p[1:0] == WORD_D);
        digest_due.push_back(due);
      end
      restart_message();
    end
  endtask

  always @(posedge clk) begin
    md5_out_t due;
    if (rst) begin
      restart_message();
      digest_due.delete();
    end else begin
      if (dig_valid && !dig_stall) begin
        if (digest_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: unexpected digest word %h index %0d last %0b", $realtime,
                     dig.digest_word, dig.word_index, dig.last_word);
          end
        end else begin
          due = digest_due.pop_front();
          if (dig.digest_word !== due.digest_word || dig.word_index !== due.word_index ||
              dig.last_word !== due.last_word) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: digest expected %h/%0d/%0b, got %h/%0d/%0b", $realtime,
                       due.digest_word, due.word_index, due.last_word,
                       dig.digest_word, dig.word_index, dig.last_word);
            end
          end
        end
      end
      if (msg_valid && !msg_stall) md5_absorb(msg);
    end
    pending = digest_due.size();
  end

endmodule

/* verif/testbench.sv */
// testbench: drives byte requests into md5_hash_engine with random idling and stalls, and
// gives the verdict from the failure count of md5_digest_checker.
// Depends on md5_pkg, md5_hash_engine and md5_digest_checker.
`timescale 1ns / 1ps

module testbench;
  import md5_pkg::*;

  localparam int HoldCycles = 1000;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     msg_valid = 1'b0;
  logic     msg_stall;
  md5_in_t  msg = '0;
  logic     dig_valid;
  logic     dig_stall = 1'b0;
  md5_out_t dig;
  int       mismatches;
  int       pending;
  bit       gaps_on = 1'b1;
  bit       hold_req = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  md5_hash_engine u_top (
    .clk       (clk),
    .rst       (rst),
    .msg_valid (msg_valid),
    .msg_stall (msg_stall),
    .msg       (msg),
    .dig_valid (dig_valid),
    .dig_stall (dig_stall),
    .dig       (dig)
  );

  md5_digest_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .msg_valid  (msg_valid),
    .msg_stall  (msg_stall),
    .msg        (msg),
    .dig_valid  (dig_valid),
    .dig_stall  (dig_stall),
    .dig        (dig),
    .mismatches (mismatches),
    .pending    (pending)
  );

  function automatic md5_in_t make_request(input logic [7:0] data, input logic has,
                                           input logic ends);
    md5_in_t r;
    r.data_byte = data;
    r.has_byte = has;
    r.is_last = ends;
    return r;
  endfunction

  task automatic push_request(input md5_in_t item);
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      msg_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    msg <= item;
    msg_valid <= 1'b1;
    do @(posedge clk); while (msg_stall);
  endtask

  task automatic send_message(input int len, input bit byte_on_last);
    int n;
    for (n = 0; n < len; n++) begin
      if ($urandom_range(0, 9) == 0) begin
        push_request(make_request(8'($urandom_range(0, 255)), 1'b0, 1'b0));
      end
      push_request(make_request(8'($urandom_range(0, 255)), 1'b1,
                                byte_on_last && n == len - 1));
    end
    if (!(byte_on_last && len > 0)) begin
      push_request(make_request(8'($urandom_range(0, 255)), 1'b0, 1'b1));
    end
  endtask

  // The receiver either holds off for a long counted stretch on request, or stalls in bursts.
  always begin
    @(negedge clk);
    if (hold_req) begin
      dig_stall <= 1'b1;
      repeat (HoldCycles) @(negedge clk);
      hold_req = 1'b0;
      dig_stall <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 4) == 0) begin
      dig_stall <= 1'b1;
      repeat ($urandom_range(0, 5)) @(negedge clk);
    end else begin
      dig_stall <= 1'b0;
    end
  end

  initial begin
    int  sent;
    int  msg_count;
    int  len;
    int  pick;
    bit  byte_on_last;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    push_request(make_request(8'h00, 1'b0, 1'b1));
    push_request(make_request(8'hff, 1'b0, 1'b0));
    push_request(make_request(8'hff, 1'b1, 1'b1));
    push_request(make_request(8'h00, 1'b1, 1'b0));
    push_request(make_request(8'hff, 1'b1, 1'b0));
    push_request(make_request(8'h80, 1'b1, 1'b0));
    push_request(make_request(8'h7f, 1'b1, 1'b0));
    push_request(make_request(8'h55, 1'b0, 1'b0));
    push_request(make_request(8'haa, 1'b1, 1'b0));
    push_request(make_request(8'h00, 1'b0, 1'b1));
    push_request(make_request(8'h61, 1'b1, 1'b0));
    push_request(make_request(8'h62, 1'b1, 1'b0));
    push_request(make_request(8'h63, 1'b1, 1'b1));
    push_request(make_request(8'h00, 1'b0, 1'b1));

    @(negedge clk);
    msg_valid <= 1'b0;
    wait (pending == 0);

    sent = 0;
    msg_count = 0;
    while (sent < 130) begin
      pick = $urandom_range(0, 9);
      case (msg_count)
        0: len = 56;
        1: len = 64;
        default: begin
          if (pick < 7) len = $urandom_range(0, 6);
          else len = $urandom_range(7, 30);
        end
      endcase
      byte_on_last = 1'($urandom_range(0, 1));
      if (msg_count == 1) hold_req = 1'b1;
      if (msg_count >= 2) gaps_on = 1'b0;
      send_message(len, byte_on_last);
      sent += len + ((byte_on_last && len > 0) ? 0 : 1);
      msg_count++;
    end

    @(negedge clk);
    msg_valid <= 1'b0;
    wait (pending == 0);
    repeat (150) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("md5_hash_engine: match");
    end else begin
      $display("md5_hash_engine: mismatch");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("md5_hash_engine: mismatch");
    $finish;
  end

endmodule

/* md5_hash_engine.f */
rtl/md5_pkg.sv
rtl/md5_datapath.sv
rtl/md5_ctrl.sv
rtl/md5_hash_engine.sv
verif/md5_digest_checker.sv
verif/testbench.sv
